>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, gated by reset
`define SD_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("sd assertion failed: same-cycle implication");

// next-cycle implication, gated by reset
`define SD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("sd assertion failed: next-cycle implication");

`endif

>>> rtl/sd_pkg.sv
// ----------------------------------------------------------------------------
// sd_pkg
// Types, constants and the arctangent table for the similarity decomposer.
// ----------------------------------------------------------------------------
package sd_pkg;

  localparam int ITERATIONS = 16;
  localparam int MAX_STEPS  = 24;
  localparam int STEPS      = (ITERATIONS < 1) ? 1 :
                              (ITERATIONS > MAX_STEPS) ? MAX_STEPS : ITERATIONS;
  localparam int SHIFT_W    = $clog2(MAX_STEPS);
  localparam int GUARD_BITS = 8;
  localparam int XW         = 35;
  localparam int HALF_W     = 17;
  localparam int K_W        = 30;
  localparam int PP_W       = HALF_W + K_W;
  localparam int SUM_W      = 64;
  localparam int SCALE_SH   = 30 + GUARD_BITS;
  localparam int MAG_W      = SUM_W - SCALE_SH;

  localparam logic [63:0] KINF_Q30 = 64'd652032874;
  localparam logic [63:0] KINF_2_3 = 64'd434688582;
  localparam logic [63:0] GAIN_K64 =
    KINF_Q30 + ((KINF_2_3 + (64'd1 << (2 * STEPS - 1))) >> (2 * STEPS));
  localparam logic [K_W-1:0] GAIN_K = GAIN_K64[K_W-1:0];

  localparam logic [SUM_W-1:0] ROUND_C   = SUM_W'(64'd1 << (SCALE_SH - 1));
  localparam logic [MAG_W-1:0] POS_LIMIT = MAG_W'(8388607);
  localparam logic [MAG_W-1:0] NEG_LIMIT = MAG_W'(8388608);
  localparam logic [31:0]      HALF_TURN = 32'h8000_0000;
  localparam logic [31:0]      ANG_RND   = 32'h0000_8000;

  typedef struct packed {
    logic signed [23:0] cos_term;
    logic signed [23:0] sin_term;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_shift_x;
    logic signed [31:0] out_shift_y;
    logic signed [15:0] angle;
    logic signed [23:0] scale_value;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic               zero;
    logic               neg;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic [31:0]        z;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
  } cordic_t;

  function automatic logic [31:0] atan_lut(input logic [SHIFT_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/sd_cell.sv
// ----------------------------------------------------------------------------
// sd_cell
// One CORDIC vectoring micro-rotation, registered, passing its item on.
// ----------------------------------------------------------------------------
module sd_cell
  import sd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic [SHIFT_W-1:0] shift,
  input  logic [31:0]        atan_val,
  input  logic               in_vld,
  input  cordic_t            in_d,
  output logic               out_vld,
  output cordic_t            out_d
);

  logic    vld_r;
  cordic_t d_r;
  cordic_t d_nxt;
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;

  always_comb begin
    dx    = in_d.y >>> shift;
    dy    = in_d.x >>> shift;
    d_nxt = in_d;
    if (!in_d.y[XW-1]) begin
      d_nxt.x = in_d.x + dx;
      d_nxt.y = in_d.y - dy;
      d_nxt.z = in_d.z + atan_val;
    end else begin
      d_nxt.x = in_d.x - dx;
      d_nxt.y = in_d.y + dy;
      d_nxt.z = in_d.z - atan_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_d   = d_r;

endmodule

>>> rtl/sd_scale.sv
// ----------------------------------------------------------------------------
// sd_scale
// Gain correction by two registered partial products, rounding, sign and
// saturation of the scale, and rounding of the binary angle.
// ----------------------------------------------------------------------------
module sd_scale
  import sd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_vld,
  input  cordic_t   in_d,
  output logic      out_vld,
  output out_item_t out_d
);

  logic              vld_r;
  logic [PP_W-1:0]   pp_hi_r;
  logic [PP_W-1:0]   pp_lo_r;
  logic [PP_W-1:0]   pp_hi_nxt;
  logic [PP_W-1:0]   pp_lo_nxt;
  logic              neg_r;
  logic              zero_r;
  logic [15:0]       angle_r;
  logic [15:0]       angle_nxt;
  logic [31:0]       z_rnd;
  logic signed [31:0] sx_r;
  logic signed [31:0] sy_r;
  logic [SUM_W-1:0]  sum;
  logic [MAG_W-1:0]  mag;
  logic [MAG_W-1:0]  mag_clip;
  logic [MAG_W-1:0]  mag_neg;
  logic              sat;

  always_comb begin
    pp_hi_nxt = PP_W'(in_d.x[2*HALF_W-1:HALF_W]) * PP_W'(GAIN_K);
    pp_lo_nxt = PP_W'(in_d.x[HALF_W-1:0]) * PP_W'(GAIN_K);
    z_rnd     = in_d.z + ANG_RND;
    angle_nxt = z_rnd[31:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_hi_r <= pp_hi_nxt;
      pp_lo_r <= pp_lo_nxt;
      neg_r   <= in_d.neg;
      zero_r  <= in_d.zero;
      angle_r <= angle_nxt;
      sx_r    <= in_d.sx;
      sy_r    <= in_d.sy;
    end
  end

  always_comb begin
    sum = (SUM_W'(pp_hi_r) << HALF_W) + SUM_W'(pp_lo_r) + ROUND_C;
    mag = zero_r ? '0 : sum[SUM_W-1:SCALE_SH];
    sat = 1'b0;
    mag_clip = mag;
    if (neg_r) begin
      if (mag > NEG_LIMIT) begin
        mag_clip = NEG_LIMIT;
        sat      = 1'b1;
      end
    end else begin
      if (mag > POS_LIMIT) begin
        mag_clip = POS_LIMIT;
        sat      = 1'b1;
      end
    end
    mag_neg = -mag_clip;
    out_d.out_shift_x = sx_r;
    out_d.out_shift_y = sy_r;
    out_d.angle       = zero_r ? '0 : angle_r;
    out_d.scale_value = neg_r ? mag_neg[23:0] : mag_clip[23:0];
    out_d.saturated   = sat;
  end

  assign out_vld = vld_r;

endmodule

>>> rtl/similarity_decompose.sv
// ----------------------------------------------------------------------------
// similarity_decompose
// Splits a rotation-scale-translation matrix into shifts, angle and scale
// with a chain of CORDIC vectoring cells and a split-product gain stage.
//
//   channel  ports                          item
//   input    in_valid  in_stall  in_data    in_item_t  (cos, sin, shifts)
//   output   out_valid out_stall out_data   out_item_t (shifts, angle, scale)
//
// One item per cycle while in_stall is low; one register per cell, one
// partial-product stage and one output register lie on the path.
// Synchronous active-low reset clears all valid bits; payload is not reset.
// A skid register takes the item leaving the chain while out_stall holds the
// output register; in_stall rises only while that skid register is full.
// ----------------------------------------------------------------------------
module similarity_decompose
  import sd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic [STEPS:0] stg_v;
  cordic_t        stg_d [STEPS+1];
  logic           pipe_en;
  logic signed [XW-1:0] c_w;
  logic signed [XW-1:0] s_w;
  logic           fin_v;
  out_item_t      fin_d;
  logic           out_v_r;
  out_item_t      out_d_r;
  logic           skid_v_r;
  out_item_t      skid_d_r;

  assign pipe_en  = !skid_v_r;
  assign in_stall = skid_v_r;

  always_comb begin
    c_w = XW'(in_data.cos_term) <<< GUARD_BITS;
    s_w = XW'(in_data.sin_term) <<< GUARD_BITS;
    stg_v[0]      = in_valid;
    stg_d[0].zero = (in_data.cos_term == '0) && (in_data.sin_term == '0);
    stg_d[0].neg  = in_data.cos_term[23];
    stg_d[0].x    = in_data.cos_term[23] ? -c_w : c_w;
    stg_d[0].y    = in_data.cos_term[23] ? -s_w : s_w;
    stg_d[0].z    = in_data.cos_term[23] ? HALF_TURN : '0;
    stg_d[0].sx   = in_data.shift_x;
    stg_d[0].sy   = in_data.shift_y;
  end

  for (genvar g = 0; g < STEPS; g++) begin : g_cell
    sd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (pipe_en),
      .shift    (SHIFT_W'(g)),
      .atan_val (atan_lut(SHIFT_W'(g))),
      .in_vld   (stg_v[g]),
      .in_d     (stg_d[g]),
      .out_vld  (stg_v[g+1]),
      .out_d    (stg_d[g+1])
    );
  end

  sd_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (pipe_en),
    .in_vld  (stg_v[STEPS]),
    .in_d    (stg_d[STEPS]),
    .out_vld (fin_v),
    .out_d   (fin_d)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (!out_stall) begin
        skid_v_r <= 1'b0;
      end
    end else if (!out_v_r || !out_stall) begin
      out_v_r <= fin_v;
    end else if (fin_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (!out_stall) begin
        out_d_r <= skid_d_r;
      end
    end else if (!out_v_r || !out_stall) begin
      out_d_r <= fin_d;
    end else if (fin_v) begin
      skid_d_r <= fin_d;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

endmodule

>>> rtl/sd_checker.sv
// ----------------------------------------------------------------------------
// sd_checker
// Port-level checks on the similarity decomposer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sd_checker
  import sd_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  logic out_held;
  logic sat_seen;
  logic at_limit;

  assign out_held = out_valid && out_stall;
  assign sat_seen = out_valid && out_data.saturated;
  assign at_limit = (out_data.scale_value == 24'sh7fffff) ||
                    (out_data.scale_value == 24'sh800000);

  `SD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_held, out_valid && $stable(out_data))
  `SD_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, $past(out_held))
  `SD_ASSERT_IMP(a_stall_out, clk, rst_n, in_stall, out_valid)
  `SD_ASSERT_IMP(a_sat_limit, clk, rst_n, sat_seen, at_limit)

endmodule

bind similarity_decompose sd_checker u_sd_checker (.*);

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for similarity_decompose. A directed table covers the
// zero vector, axis and diagonal extremes, the half turn and both saturation
// limits. Random matrices follow: full-range, small, near unit scale and
// near the clamp. Each result is checked field by field against an in-bench
// CORDIC vectoring model. The sender runs in bursts and the receiver stalls
// in patterns, with one long output hold and one full drain pause.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sd_pkg::in_item_t;
  import sd_pkg::out_item_t;
  import sd_pkg::STEPS;

  localparam int          RANDOM_ITEMS = 1730;
  localparam int          HOLD_CYCLES  = 300;
  localparam logic [63:0] GAIN_BASE    = 64'd652032874;
  localparam logic [63:0] GAIN_TAIL    = 64'd434688582;
  localparam logic [63:0] MAG_ROUND    = 64'd1 << 37;
  localparam logic [31:0] PI_CODE      = 32'h8000_0000;
  localparam logic [31:0] ANGLE_ROUND  = 32'h0000_8000;
  localparam longint      POS_CLAMP    = 64'sd8388607;
  localparam longint      NEG_CLAMP    = 64'sd8388608;

  localparam logic [31:0] ATAN_STEP [0:23] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct {
    in_item_t  stim;
    bit        fixed;
    out_item_t want;
  } matrix_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  out_item_t   pending_results[$];
  matrix_row_t matrix_table[$];
  int          burst_left;
  int          matrices_sent;
  int          results_checked;
  int          mismatch_count;
  int          zero_vectors;
  int          clamp_hits;
  int          half_turns;
  int          input_stall_cycles;
  bit          long_hold_done;

  similarity_decompose uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  function automatic out_item_t decompose_matrix(input in_item_t m);
    out_item_t   r;
    longint      x;
    longint      y;
    longint      dx;
    longint      dy;
    longint      mag;
    logic [31:0] z;
    logic [31:0] z_rounded;
    logic [63:0] gain;
    logic [63:0] prod;
    bit          flip;
    bit          clamped;
    r.out_shift_x = m.shift_x;
    r.out_shift_y = m.shift_y;
    flip    = $signed(m.cos_term) < 0;
    z       = '0;
    mag     = 0;
    clamped = 1'b0;
    if (m.cos_term != 0 || m.sin_term != 0) begin
      x = longint'($signed(m.cos_term)) * 256;
      y = longint'($signed(m.sin_term)) * 256;
      if (flip) begin
        x = -x;
        y = -y;
        z = PI_CODE;
      end
      for (int i = 0; i < STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + ATAN_STEP[i];
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - ATAN_STEP[i];
        end
      end
      gain = GAIN_BASE + ((GAIN_TAIL + (64'd1 << (2 * STEPS - 1))) >> (2 * STEPS));
      prod = x;
      prod = prod * gain + MAG_ROUND;
      mag  = longint'(prod >> 38);
    end
    if (flip) begin
      if (mag > NEG_CLAMP) begin
        mag     = NEG_CLAMP;
        clamped = 1'b1;
      end
      mag = -mag;
    end else if (mag > POS_CLAMP) begin
      mag     = POS_CLAMP;
      clamped = 1'b1;
    end
    z_rounded     = z + ANGLE_ROUND;
    r.angle       = z_rounded[31:16];
    r.scale_value = mag[23:0];
    r.saturated   = clamped;
    return r;
  endfunction

  function automatic logic [23:0] pick_coord();
    int unsigned v;
    case ($urandom_range(0, 7))
      0, 1, 2: v = $urandom;
      3:       v = $urandom_range(0, 300);
      4:       v = 64536 + $urandom_range(0, 2000);
      5:       v = 0;
      6:       v = $urandom_range(5800000, 8388607);
      default: v = $urandom_range(0, 65535) << $urandom_range(0, 7);
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    return v[23:0];
  endfunction

  function automatic logic [31:0] pick_shift();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic add_row(input logic [23:0] c, input logic [23:0] s,
                         input logic [31:0] sx, input logic [31:0] sy,
                         input bit fixed, input logic [15:0] angle,
                         input logic [23:0] scale, input logic sat);
    matrix_row_t row;
    row.stim                  = '{cos_term: c, sin_term: s, shift_x: sx, shift_y: sy};
    row.fixed                 = fixed;
    row.want.out_shift_x      = sx;
    row.want.out_shift_y      = sy;
    row.want.angle            = angle;
    row.want.scale_value      = scale;
    row.want.saturated        = sat;
    matrix_table.push_back(row);
  endtask

  task automatic offer_item(input in_item_t d, input out_item_t want);
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(want);
    matrices_sent++;
    if (d.cos_term == 0 && d.sin_term == 0) zero_vectors++;
    burst_left--;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (got.saturated) clamp_hits++;
    if (got.angle == 16'h8000) half_turns++;
    if (pending_results.size() == 0) begin
      if (mismatch_count < 10)
        $display("[%0t] unexpected result: %p", $realtime, got);
      mismatch_count++;
      return;
    end
    want = pending_results.pop_front();
    results_checked++;
    if (got.out_shift_x !== want.out_shift_x || got.out_shift_y !== want.out_shift_y ||
        got.angle !== want.angle || got.scale_value !== want.scale_value ||
        got.saturated !== want.saturated) begin
      if (mismatch_count < 10) begin
        $display("[%0t] mismatch on result %0d", $realtime, results_checked);
        $display("  shift_x exp %h got %h  shift_y exp %h got %h",
                 want.out_shift_x, got.out_shift_x, want.out_shift_y, got.out_shift_y);
        $display("  angle exp %h got %h  scale exp %h got %h  sat exp %b got %b",
                 want.angle, got.angle, want.scale_value, got.scale_value,
                 want.saturated, got.saturated);
      end
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result(out_data);
    if (rst_n && in_valid && in_stall) input_stall_cycles++;
  end

  initial begin : receiver_stall
    int mode;
    int span;
    @(posedge clk iff rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 128);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
      if (!long_hold_done && results_checked >= 300) begin
        long_hold_done = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(posedge clk);
          out_stall <= 1'b1;
        end
      end
    end
  end

  initial begin : time_limit
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    in_item_t m;
    add_row(24'h000000, 24'h000000, 32'h0000_0000, 32'h0000_0000, 1, 16'h0000, 24'h0, 0);
    add_row(24'h000000, 24'h000000, 32'h7fff_ffff, 32'h8000_0000, 1, 16'h0000, 24'h0, 0);
    add_row(24'h000000, 24'h000000, 32'h8000_0000, 32'h7fff_ffff, 1, 16'h0000, 24'h0, 0);
    add_row(24'h7fffff, 24'h000000, 32'hffff_ffff, 32'h0000_0001, 0, '0, '0, 0);
    add_row(24'h800000, 24'h000000, 32'h0001_0000, 32'hffff_0000, 0, '0, '0, 0);
    add_row(24'h000000, 24'h7fffff, 32'h5555_5555, 32'haaaa_aaaa, 0, '0, '0, 0);
    add_row(24'h000000, 24'h800000, 32'haaaa_aaaa, 32'h5555_5555, 0, '0, '0, 0);
    add_row(24'h7fffff, 24'h7fffff, 32'h0000_0000, 32'h0000_0000, 0, '0, '0, 0);
    add_row(24'h800000, 24'h800000, 32'h0000_0000, 32'h0000_0000, 0, '0, '0, 0);
    add_row(24'h800000, 24'h7fffff, 32'h1234_5678, 32'h8765_4321, 0, '0, '0, 0);
    add_row(24'h7fffff, 24'h800000, 32'h8765_4321, 32'h1234_5678, 0, '0, '0, 0);
    add_row(24'hffffff, 24'h000000, 32'h0000_0000, 32'h0000_0000, 0, '0, '0, 0);
    add_row(24'h000001, 24'h000000, 32'h0000_0000, 32'h0000_0000, 0, '0, '0, 0);
    add_row(24'h000000, 24'h000001, 32'h0000_0000, 32'h0000_0000, 0, '0, '0, 0);
    add_row(24'h000000, 24'hffffff, 32'h0000_0000, 32'h0000_0000, 0, '0, '0, 0);
    add_row(24'h010000, 24'h000000, 32'h0010_0000, 32'hfff0_0000, 0, '0, '0, 0);
    add_row(24'hff0000, 24'h000000, 32'hfff0_0000, 32'h0010_0000, 0, '0, '0, 0);
    add_row(24'h00b505, 24'h00b505, 32'h0000_0000, 32'h0000_0000, 0, '0, '0, 0);
    add_row(24'hff4afb, 24'hff4afb, 32'h0000_0000, 32'h0000_0000, 0, '0, '0, 0);
    add_row(24'hff0000, 24'h000001, 32'h0000_0000, 32'h0000_0000, 0, '0, '0, 0);
    add_row(24'hff0000, 24'hffffff, 32'h0000_0000, 32'h0000_0000, 0, '0, '0, 0);
    add_row(24'h5b8d80, 24'h5b8d80, 32'h0000_0000, 32'h0000_0000, 0, '0, '0, 0);
    add_row(24'ha47280, 24'h5b8d80, 32'h0000_0000, 32'h0000_0000, 0, '0, '0, 0);
    add_row(24'h5a5a5a, 24'ha5a5a5, 32'h5a5a_5a5a, 32'ha5a5_a5a5, 0, '0, '0, 0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (matrix_table[i])
      offer_item(matrix_table[i].stim,
                 matrix_table[i].fixed ? matrix_table[i].want
                                       : decompose_matrix(matrix_table[i].stim));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      m.cos_term = pick_coord();
      m.sin_term = pick_coord();
      m.shift_x  = pick_shift();
      m.shift_y  = pick_shift();
      offer_item(m, decompose_matrix(m));
      if (n == RANDOM_ITEMS / 2) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        burst_left = 0;
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (STEPS + 8) @(posedge clk);

    $display("Decomposed %0d matrices, %0d zero vectors, %0d clamped scales, %0d half turns.",
             matrices_sent, zero_vectors, clamp_hits, half_turns);
    $display("Checked %0d results with %0d mismatches; input stalled for %0d cycles.",
             results_checked, mismatch_count, input_stall_cycles);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
